// File: rtl/c2d_pkg.sv
package c2d_pkg;

  localparam int LANE_BITS       = 16;
  localparam int LANES           = 3;
  localparam int PIX_BITS        = LANE_BITS * LANES;
  localparam int KSIZE           = 3;
  localparam int COEF_BITS       = 16;
  localparam int FRAC_BITS       = 12;
  localparam int PROD_BITS       = LANE_BITS + 1 + COEF_BITS;
  localparam int SUM_BITS        = PROD_BITS + 4;
  localparam int RES_BITS        = SUM_BITS - FRAC_BITS;
  localparam int ROW_BITS        = 16;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int CFG_DATA_BITS   = 48;
  localparam int CFG_IDX_BITS    = 3;
  localparam int FIFO_DEPTH      = 8;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_CHANNELS = 3'd2,
    REG_KEEP     = 3'd3,
    REG_K_TOP    = 3'd4,
    REG_K_MID    = 3'd5,
    REG_K_BOT    = 3'd6
  } cfg_reg_t;

  typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_BITS-1:0]  win_t;
  typedef logic [KSIZE-1:0][KSIZE-1:0][COEF_BITS-1:0] kernel_t;
  typedef logic [LANES-1:0][RES_BITS-1:0]             res_t;

  typedef struct packed {
    logic       keep;
    logic [1:0] nch;
  } mode_t;

endpackage

// File: rtl/c2d_mac.sv
module c2d_mac import c2d_pkg::*; #(
  parameter int TAG_W = 27
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  win_t             in_win,
  input  kernel_t          in_kernel,
  input  logic [TAG_W-1:0] in_tag,
  input  mode_t            mode,
  output logic             out_vld,
  output logic [TAG_W-1:0] out_tag,
  output res_t             out_res
);

  logic signed [PROD_BITS-1:0] prod_nxt [LANES][KSIZE][KSIZE];
  logic signed [PROD_BITS-1:0] prod_r   [LANES][KSIZE][KSIZE];
  logic signed [SUM_BITS-1:0]  sum_nxt  [LANES];
  logic signed [SUM_BITS-1:0]  sum_r    [LANES];
  logic signed [RES_BITS+1:0]  total;
  res_t                        res_nxt;
  logic                        vc_r, vd_r;
  logic [TAG_W-1:0]            tc_r, td_r;

  always_comb begin
    for (int ch = 0; ch < LANES; ch++) begin
      for (int fy = 0; fy < KSIZE; fy++) begin
        for (int fx = 0; fx < KSIZE; fx++) begin
          prod_nxt[ch][fy][fx] = $signed({1'b0, in_win[fy][fx][ch*LANE_BITS +: LANE_BITS]})
                               * $signed(in_kernel[fy][fx]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < LANES; ch++) begin
      sum_nxt[ch] = '0;
      for (int fy = 0; fy < KSIZE; fy++) begin
        for (int fx = 0; fx < KSIZE; fx++) begin
          sum_nxt[ch] = sum_nxt[ch] + SUM_BITS'(prod_r[ch][fy][fx]);
        end
      end
    end
  end

  always_comb begin
    total   = '0;
    res_nxt = '0;
    for (int ch = 0; ch < LANES; ch++) begin
      if (2'(ch) < mode.nch) begin
        total = total + (RES_BITS+2)'($signed(sum_r[ch][SUM_BITS-1:FRAC_BITS]));
        if (mode.keep) begin
          res_nxt[ch] = sum_r[ch][SUM_BITS-1:FRAC_BITS];
        end
      end
    end
    if (!mode.keep) begin
      res_nxt[0] = total[RES_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r    <= 1'b0;
      vd_r    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vc_r    <= in_vld;
      vd_r    <= vc_r;
      out_vld <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    tc_r    <= in_tag;
    sum_r   <= sum_nxt;
    td_r    <= tc_r;
    out_res <= res_nxt;
    out_tag <= td_r;
  end

endmodule

// File: rtl/conv2d_clamp_edge_3x3.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_sample_zero, in_sample_one, in_sample_two
// out      output     out_valid / out_ready  out_centre_column, out_centre_row,
//                                            out_result_zero/one/two, out_run_end
// cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// One word is taken per cycle while in_ready is high; a word that causes several
// results holds the input until its last result is issued, since the single
// convolution engine issues one result a cycle while the result queue has room.
// Reset is synchronous; the line stores are not cleared and need no clearing pass.
// A stalled output fills an eight-entry result queue before the input stalls.
module conv2d_clamp_edge_3x3 import c2d_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int COL_W      = $clog2(MAX_WIDTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [LANE_BITS-1:0]       in_sample_zero,
  input  logic [LANE_BITS-1:0]       in_sample_one,
  input  logic [LANE_BITS-1:0]       in_sample_two,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [COL_W-1:0]           out_centre_column,
  output logic [ROW_BITS-1:0]        out_centre_row,
  output logic signed [RES_BITS-1:0] out_result_zero,
  output logic signed [RES_BITS-1:0] out_result_one,
  output logic signed [RES_BITS-1:0] out_result_two,
  output logic                       out_run_end,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int WC_W  = (COL_W + 1 > WIDTH_REG_BITS) ? COL_W + 1 : WIDTH_REG_BITS;
  localparam int TAG_W = COL_W + ROW_BITS + 1;
  localparam int FP_W  = $clog2(FIFO_DEPTH);
  localparam int FC_W  = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH_REG_BITS-1:0] width_r;
  logic [ROW_BITS-1:0]       height_r;
  logic [1:0]                nch_r;
  logic                      keep_r;
  logic [CFG_DATA_BITS-1:0]  ktop_r, kmid_r, kbot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_REG_BITS'(1024);
      height_r <= ROW_BITS'(1);
      nch_r    <= 2'd1;
      keep_r   <= 1'b1;
      ktop_r   <= '0;
      kmid_r   <= CFG_DATA_BITS'(4096);
      kbot_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:    width_r  <= cfg_data[WIDTH_REG_BITS-1:0];
        REG_HEIGHT:   height_r <= cfg_data[ROW_BITS-1:0];
        REG_CHANNELS: nch_r    <= cfg_data[1:0];
        REG_KEEP:     keep_r   <= cfg_data[0];
        REG_K_TOP:    ktop_r   <= cfg_data;
        REG_K_MID:    kmid_r   <= cfg_data;
        REG_K_BOT:    kbot_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [WC_W-1:0]     w_eff;
  logic [ROW_BITS-1:0] h_eff;
  mode_t               mode;
  kernel_t             kernel;

  always_comb begin
    w_eff = WC_W'(width_r);
    if (w_eff == '0) begin
      w_eff = WC_W'(1);
    end else if (w_eff > WC_W'(MAX_WIDTH)) begin
      w_eff = WC_W'(MAX_WIDTH);
    end
    h_eff     = (height_r == '0) ? ROW_BITS'(1) : height_r;
    mode.keep = keep_r;
    mode.nch  = (nch_r == 2'd0) ? 2'd1 : nch_r;
    for (int fx = 0; fx < KSIZE; fx++) begin
      kernel[0][fx] = ktop_r[fx*COEF_BITS +: COEF_BITS];
      kernel[1][fx] = kmid_r[fx*COEF_BITS +: COEF_BITS];
      kernel[2][fx] = kbot_r[fx*COEF_BITS +: COEF_BITS];
    end
  end

  // Position of the incoming word, with wrap after a geometry change.
  logic [COL_W-1:0]    col_cnt_r, col_cnt_nxt, cur_c;
  logic [ROW_BITS-1:0] row_cnt_r, row_cnt_nxt, cur_r;
  logic [ROW_BITS:0]   r_tmp;
  logic                last_col, last_row;
  logic [3:0]          cur_mask;
  logic [PIX_BITS-1:0] cur_px;

  always_comb begin
    cur_c = col_cnt_r;
    r_tmp = {1'b0, row_cnt_r};
    if (WC_W'(col_cnt_r) >= w_eff) begin
      cur_c = '0;
      r_tmp = r_tmp + 1'b1;
    end
    if (r_tmp >= {1'b0, h_eff}) begin
      r_tmp = '0;
    end
    cur_r    = r_tmp[ROW_BITS-1:0];
    last_col = (WC_W'(cur_c) == w_eff - 1'b1);
    last_row = (cur_r == h_eff - 1'b1);
    col_cnt_nxt = last_col ? '0 : cur_c + 1'b1;
    row_cnt_nxt = last_col ? (last_row ? '0 : cur_r + 1'b1) : cur_r;
    cur_mask[0] = (cur_r != '0) && (cur_c != '0);
    cur_mask[1] = (cur_r != '0) && last_col;
    cur_mask[2] = last_row && (cur_c != '0);
    cur_mask[3] = last_row && last_col;
    cur_px = {LANE_BITS'(in_sample_two[SAMPLE_BITS-1:0]),
              LANE_BITS'(in_sample_one[SAMPLE_BITS-1:0]),
              LANE_BITS'(in_sample_zero[SAMPLE_BITS-1:0])};
  end

  logic                accept, advance;
  logic                a_vld_r;
  logic [PIX_BITS-1:0] a_px_r, a_old, a_rec, rd_old_r, rd_rec_r, fwd_old_r, fwd_rec_r;
  logic [COL_W-1:0]    a_c_r;
  logic [ROW_BITS-1:0] a_r_r;
  logic [3:0]          a_mask_r;
  logic                fwd_r;
  logic [PIX_BITS-1:0] old_mem [MAX_WIDTH];
  logic [PIX_BITS-1:0] rec_mem [MAX_WIDTH];

  assign accept   = in_valid && in_ready;
  assign in_ready = !a_vld_r || advance;

  always_comb begin
    if (a_r_r == '0) begin
      a_old = a_px_r;
      a_rec = a_px_r;
    end else if (fwd_r) begin
      a_old = fwd_old_r;
      a_rec = fwd_rec_r;
    end else begin
      a_old = rd_old_r;
      a_rec = rd_rec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      old_mem[a_c_r] <= a_rec;
      rec_mem[a_c_r] <= a_px_r;
    end
    if (accept) begin
      rd_old_r <= old_mem[cur_c];
      rd_rec_r <= rec_mem[cur_c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      fwd_r     <= 1'b0;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      if (accept) begin
        a_vld_r   <= 1'b1;
        fwd_r     <= advance && (a_c_r == cur_c);
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
      end else if (advance) begin
        a_vld_r <= 1'b0;
        fwd_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_px_r    <= cur_px;
      a_c_r     <= cur_c;
      a_r_r     <= cur_r;
      a_mask_r  <= cur_mask;
      fwd_old_r <= a_rec;
      fwd_rec_r <= a_px_r;
    end
  end

  // Window and result issue.
  win_t                window_r, win_sel;
  logic [3:0]          b_mask_r, first, rem;
  logic [COL_W-1:0]    b_c_r, iss_col;
  logic [ROW_BITS-1:0] b_r_r, iss_row;
  logic                b_busy, issue, row_edge, col_edge;
  logic [FC_W-1:0]     used_r;
  logic                pop;

  assign b_busy   = (b_mask_r != '0);
  assign issue    = b_busy && (used_r < FC_W'(FIFO_DEPTH));
  assign first    = b_mask_r & (~b_mask_r + 4'd1);
  assign rem      = b_mask_r & ~first;
  assign advance  = a_vld_r && (!b_busy || (issue && rem == '0));
  assign row_edge = first[2] | first[3];
  assign col_edge = first[1] | first[3];
  assign iss_col  = col_edge ? b_c_r : b_c_r - 1'b1;
  assign iss_row  = row_edge ? b_r_r : b_r_r - 1'b1;

  always_comb begin
    for (int fy = 0; fy < KSIZE; fy++) begin
      for (int fx = 0; fx < KSIZE; fx++) begin
        win_sel[fy][fx] = window_r[row_edge ? ((fy == 0) ? 1 : 2) : fy]
                                  [col_edge ? ((fx == 0) ? 1 : 2) : fx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_mask_r <= '0;
      window_r <= '0;
    end else if (advance) begin
      b_mask_r <= a_mask_r;
      for (int k = 0; k < KSIZE; k++) begin
        if (a_c_r == '0) begin
          window_r[0][k] <= a_old;
          window_r[1][k] <= a_rec;
          window_r[2][k] <= a_px_r;
        end else if (k < KSIZE - 1) begin
          window_r[0][k] <= window_r[0][k+1];
          window_r[1][k] <= window_r[1][k+1];
          window_r[2][k] <= window_r[2][k+1];
        end else begin
          window_r[0][k] <= a_old;
          window_r[1][k] <= a_rec;
          window_r[2][k] <= a_px_r;
        end
      end
    end else if (issue) begin
      b_mask_r <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_c_r <= a_c_r;
      b_r_r <= a_r_r;
    end
  end

  logic             m_vld;
  logic [TAG_W-1:0] m_tag;
  res_t             m_res;

  c2d_mac #(
    .TAG_W (TAG_W)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (issue),
    .in_win    (win_sel),
    .in_kernel (kernel),
    .in_tag    ({iss_col, iss_row, rem == '0}),
    .mode      (mode),
    .out_vld   (m_vld),
    .out_tag   (m_tag),
    .out_res   (m_res)
  );

  // Result queue; issue is held back so that it never overflows.
  logic [COL_W-1:0]    f_col [FIFO_DEPTH];
  logic [ROW_BITS-1:0] f_row [FIFO_DEPTH];
  res_t                f_res [FIFO_DEPTH];
  logic                f_end [FIFO_DEPTH];
  logic [FP_W-1:0]     wp_r, rp_r;
  logic [FC_W-1:0]     cnt_r;

  assign out_valid         = (cnt_r != '0);
  assign pop               = out_valid && out_ready;
  assign out_centre_column = f_col[rp_r];
  assign out_centre_row    = f_row[rp_r];
  assign out_result_zero   = f_res[rp_r][0];
  assign out_result_one    = f_res[rp_r][1];
  assign out_result_two    = f_res[rp_r][2];
  assign out_run_end       = f_end[rp_r];

  always_ff @(posedge clk) begin
    if (m_vld) begin
      f_col[wp_r] <= m_tag[TAG_W-1 -: COL_W];
      f_row[wp_r] <= m_tag[ROW_BITS:1];
      f_res[wp_r] <= m_res;
      f_end[wp_r] <= m_tag[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      used_r <= '0;
    end else begin
      if (m_vld) begin
        wp_r <= (wp_r == FP_W'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == FP_W'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r  <= cnt_r + FC_W'(m_vld) - FC_W'(pop);
      used_r <= used_r + FC_W'(issue) - FC_W'(pop);
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= FC_W'(FIFO_DEPTH))
    else $error("more results in flight than queue entries");

  a_used_covers: assert property (@(posedge clk) disable iff (!rst_n)
    used_r >= cnt_r)
    else $error("queue holds results that were never issued");

  a_fwd_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> a_vld_r)
    else $error("line forwarding flagged without a word in the input stage");

  a_issue_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    m_vld |-> cnt_r < FC_W'(FIFO_DEPTH) || pop)
    else $error("result arrives at a full queue");

endmodule
